[src/txtr_pkg.sv]
// Shared types, constants and the 5x7 font ROM of the text rasterizer.
// Used by the front, queue, back and top-level modules; no dependencies.
package txtr_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int ADVANCE    = 6;
  localparam int ROW_W      = 40;
  localparam int GLYPHS     = 47;
  localparam int QDEPTH     = 2;

  localparam logic [5:0] GLYPH_DIGIT0 = 6'd26;
  localparam logic [5:0] GLYPH_COLON  = 6'd36;
  localparam logic [5:0] GLYPH_DOT    = 6'd37;
  localparam logic [5:0] GLYPH_SLASH  = 6'd38;
  localparam logic [5:0] GLYPH_MINUS  = 6'd39;
  localparam logic [5:0] GLYPH_PLUS   = 6'd40;
  localparam logic [5:0] GLYPH_STAR   = 6'd41;
  localparam logic [5:0] GLYPH_EQUAL  = 6'd42;
  localparam logic [5:0] GLYPH_CARET  = 6'd43;
  localparam logic [5:0] GLYPH_UNDER  = 6'd44;
  localparam logic [5:0] GLYPH_COMMA  = 6'd45;
  localparam logic [5:0] GLYPH_BLANK  = 6'd46;

  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;
  localparam logic [1:0] REG_DRAW_COLOR = 2'd3;

  localparam logic signed [16:0] COORD_MAX = 17'sd32767;

  typedef struct packed {
    logic [5:0] glyph;
    logic       first;
  } item_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [3:0]         scale;
    logic [23:0]        color;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  // Top glyph row sits in the most significant five bits of each entry.
  localparam logic [6:0][4:0] FONT_ROM [GLYPHS] = '{
    {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31},
    {5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14},
    {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
    {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    {5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
    {5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12},
    {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12},
    {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16},
    {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0},
    {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0},
    {5'd0,  5'd21, 5'd14, 5'd31, 5'd14, 5'd21, 5'd0},
    {5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0},
    {5'd4,  5'd10, 5'd17, 5'd0,  5'd0,  5'd0,  5'd0},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0}
  };

endpackage

[src/txtr_front.sv]
// Front end: accepts characters, folds case and maps each to a font index.
// Depends on txtr_pkg; pushes classified items into txtr_queue.
module txtr_front import txtr_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_first,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [7:0] up_code;
  logic [5:0] glyph;

  always_comb begin
    up_code = in_char_code;
    if (in_char_code >= "a" && in_char_code <= "z") begin
      up_code = in_char_code - 8'd32;
    end
    if (up_code >= "A" && up_code <= "Z") begin
      glyph = 6'(up_code - "A");
    end else if (up_code >= "0" && up_code <= "9") begin
      glyph = GLYPH_DIGIT0 + 6'(up_code - "0");
    end else begin
      case (up_code)
        ":":     glyph = GLYPH_COLON;
        ".":     glyph = GLYPH_DOT;
        "/":     glyph = GLYPH_SLASH;
        "-":     glyph = GLYPH_MINUS;
        "+":     glyph = GLYPH_PLUS;
        "*":     glyph = GLYPH_STAR;
        "=":     glyph = GLYPH_EQUAL;
        "^":     glyph = GLYPH_CARET;
        "_":     glyph = GLYPH_UNDER;
        ",":     glyph = GLYPH_COMMA;
        default: glyph = GLYPH_BLANK;
      endcase
    end
  end

  assign in_ready     = !q_full;
  assign q_push       = in_valid && !q_full;
  assign q_item.glyph = glyph;
  assign q_item.first = in_first;

endmodule

[src/txtr_queue.sv]
// Two-entry queue of classified characters between front and back.
// Depends on txtr_pkg for the item type and depth.
module txtr_queue import txtr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int PW = $clog2(QDEPTH);

  item_t           mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;

  assign full    = count_r == (PW+1)'(QDEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[src/txtr_back.sv]
// Back end: row sequencer that emits each scaled glyph row into an output register.
// Depends on txtr_pkg for the font ROM, config struct and state type.
module txtr_back import txtr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic [ROW_W-1:0]   out_row_bits,
  output logic [23:0]        out_row_color,
  output logic               out_last
);

  back_state_t        state_r, state_nxt;
  logic [5:0]         glyph_r, glyph_nxt;
  logic [2:0]         row_r, row_nxt;
  logic [3:0]         rep_r, rep_nxt;
  logic signed [16:0] y_r, y_nxt;
  logic signed [15:0] cursor_r, cursor_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] pixel_x_r, pixel_x_nxt;
  logic signed [15:0] pixel_y_r, pixel_y_nxt;
  logic [ROW_W-1:0]   row_bits_r, row_bits_nxt;
  logic [23:0]        color_r, color_nxt;
  logic               last_r, last_nxt;

  logic               rep_end;
  logic               row_end;
  logic signed [16:0] cursor_sum;
  logic [4:0]         glyph_row;

  function automatic logic [ROW_W-1:0] widen(input logic [4:0] row, input logic [3:0] s);
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] acc;
    logic [5:0]       sh;
    mask = (ROW_W'(1) << s) - ROW_W'(1);
    acc  = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      sh = 6'(GLYPH_COLS - 1 - c) * {2'b00, s};
      if (row[GLYPH_COLS-1-c]) begin
        acc = acc | (mask << sh);
      end
    end
    return acc;
  endfunction

  assign rep_end    = rep_r == cfg.scale - 4'd1;
  assign row_end    = row_r == 3'(GLYPH_ROWS - 1);
  assign glyph_row  = FONT_ROM[glyph_r][3'(GLYPH_ROWS - 1) - row_r];
  assign cursor_sum = 17'(cursor_r) + 17'(cfg.scale * 7'(ADVANCE));

  always_comb begin
    state_nxt     = state_r;
    glyph_nxt     = glyph_r;
    row_nxt       = row_r;
    rep_nxt       = rep_r;
    y_nxt         = y_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pixel_x_nxt   = pixel_x_r;
    pixel_y_nxt   = pixel_y_r;
    row_bits_nxt  = row_bits_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          glyph_nxt  = q_item.glyph;
          row_nxt    = '0;
          rep_nxt    = '0;
          y_nxt      = 17'(cfg.origin_y);
          cursor_nxt = q_item.first ? cfg.origin_x : cursor_r;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          pixel_x_nxt   = cursor_r;
          pixel_y_nxt   = (y_r > COORD_MAX) ? COORD_MAX[15:0] : y_r[15:0];
          row_bits_nxt  = widen(glyph_row, cfg.scale);
          color_nxt     = cfg.color;
          last_nxt      = row_end && rep_end;
          y_nxt         = y_r + 17'sd1;
          if (rep_end) begin
            rep_nxt = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            rep_nxt = rep_r + 4'd1;
          end
          if (row_end && rep_end) begin
            cursor_nxt = (cursor_sum > COORD_MAX) ? COORD_MAX[15:0] : cursor_sum[15:0];
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    glyph_r    <= glyph_nxt;
    row_r      <= row_nxt;
    rep_r      <= rep_nxt;
    y_r        <= y_nxt;
    pixel_x_r  <= pixel_x_nxt;
    pixel_y_r  <= pixel_y_nxt;
    row_bits_r <= row_bits_nxt;
    color_r    <= color_nxt;
    last_r     <= last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = pixel_x_r;
  assign out_pixel_y   = pixel_y_r;
  assign out_row_bits  = row_bits_r;
  assign out_row_color = color_r;
  assign out_last      = last_r;

endmodule

[src/scaled_5x7_text_rasterizer_core.sv]
// Scaled 5x7 text rasterizer: configuration registers, front, queue and back.
// A character passes the queue and is fetched by the back end in its idle state
// before its first row is registered. The back-end row sequencer emits one scaled
// row per cycle unless out_ready stalls it, then goes idle for the next character.
// Reset (rst_n, synchronous, active low) empties the queue and output register,
// clears the cursor and loads the register defaults.
module scaled_5x7_text_rasterizer_core import txtr_pkg::*; #(
  parameter int MAX_SCALE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic [ROW_W-1:0]   out_row_bits,
  output logic [23:0]        out_row_color,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;
  logic [3:0] scale_in;

  assign cfg_ready = 1'b1;
  assign scale_in  = cfg_data[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.scale    <= 4'd1;
      cfg_r.color    <= 24'hFFFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   cfg_r.origin_x <= cfg_data[15:0];
        REG_ORIGIN_Y:   cfg_r.origin_y <= cfg_data[15:0];
        REG_SCALE: begin
          if (scale_in == 4'd0) begin
            cfg_r.scale <= 4'd1;
          end else if (scale_in > 4'(MAX_SCALE)) begin
            cfg_r.scale <= 4'(MAX_SCALE);
          end else begin
            cfg_r.scale <= scale_in;
          end
        end
        REG_DRAW_COLOR: cfg_r.color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  txtr_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_first     (in_first),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  txtr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  txtr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_row_bits  (out_row_bits),
    .out_row_color (out_row_color),
    .out_last      (out_last)
  );

`ifndef NO_ASSERTIONS
  a_unused_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_bits >> ({2'b00, cfg_r.scale} * 6'd5)) == '0)
    else $error("row mask has bits beyond the scaled width");

  a_rows_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a character's rows");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.scale != 4'd0 && cfg_r.scale <= 4'(MAX_SCALE))
    else $error("effective scale out of range");
`endif

endmodule

[sim/tb_top.sv]
// Self-checking testbench for scaled_5x7_text_rasterizer_core: predicts every
// scaled glyph row from its own font table and cursor model, and checks them in order.
// Depends on txtr_pkg and the core RTL only.

class glyph_row_checker;
  localparam int GLYPH_H = 7;
  localparam int GLYPH_W = 5;
  localparam int ADVANCE = 6;
  localparam int SCALE_LIMIT = 8;
  localparam int BLANK_GLYPH = 46;
  localparam int COORD_TOP = 32767;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [39:0]        bits;
    logic [23:0]        color;
    logic               last;
  } row_t;

  int               glyph_rows [47][7];
  string            symbols;
  bit signed [15:0] origin_x;
  bit signed [15:0] origin_y;
  bit [3:0]         scale_reg;
  bit [23:0]        draw_color;
  int               cursor;
  row_t             pending_rows [$];
  int               chars_drawn;
  int               rows_checked;
  int               errors;

  function new();
    glyph_rows = '{
      '{14, 17, 17, 31, 17, 17, 17}, '{30, 17, 17, 30, 17, 17, 30},
      '{14, 17, 16, 16, 16, 17, 14}, '{30, 17, 17, 17, 17, 17, 30},
      '{31, 16, 16, 30, 16, 16, 31}, '{31, 16, 16, 30, 16, 16, 16},
      '{14, 17, 16, 23, 17, 17, 15}, '{17, 17, 17, 31, 17, 17, 17},
      '{31, 4, 4, 4, 4, 4, 31},      '{1, 1, 1, 1, 17, 17, 14},
      '{17, 18, 20, 24, 20, 18, 17}, '{16, 16, 16, 16, 16, 16, 31},
      '{17, 27, 21, 21, 17, 17, 17}, '{17, 25, 21, 19, 17, 17, 17},
      '{14, 17, 17, 17, 17, 17, 14}, '{30, 17, 17, 30, 16, 16, 16},
      '{14, 17, 17, 17, 21, 18, 13}, '{30, 17, 17, 30, 20, 18, 17},
      '{15, 16, 16, 14, 1, 1, 30},   '{31, 4, 4, 4, 4, 4, 4},
      '{17, 17, 17, 17, 17, 17, 14}, '{17, 17, 17, 17, 17, 10, 4},
      '{17, 17, 17, 21, 21, 21, 10}, '{17, 17, 10, 4, 10, 17, 17},
      '{17, 17, 10, 4, 4, 4, 4},     '{31, 1, 2, 4, 8, 16, 31},
      '{14, 17, 19, 21, 25, 17, 14}, '{4, 12, 4, 4, 4, 4, 14},
      '{14, 17, 1, 2, 4, 8, 31},     '{30, 1, 1, 14, 1, 1, 30},
      '{2, 6, 10, 18, 31, 2, 2},     '{31, 16, 30, 1, 1, 17, 14},
      '{6, 8, 16, 30, 17, 17, 14},   '{31, 1, 2, 4, 8, 8, 8},
      '{14, 17, 17, 14, 17, 17, 14}, '{14, 17, 17, 15, 1, 2, 12},
      '{0, 4, 4, 0, 4, 4, 0},        '{0, 0, 0, 0, 0, 12, 12},
      '{1, 1, 2, 4, 8, 16, 16},      '{0, 0, 0, 31, 0, 0, 0},
      '{0, 4, 4, 31, 4, 4, 0},       '{0, 21, 14, 31, 14, 21, 0},
      '{0, 0, 31, 0, 31, 0, 0},      '{4, 10, 17, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 31},       '{0, 0, 0, 0, 0, 4, 8},
      '{0, 0, 0, 0, 0, 0, 0}
    };
    symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789:./-+*=^_,";
    origin_x = '0;
    origin_y = '0;
    scale_reg = 4'd1;
    draw_color = 24'hFFFFFF;
    cursor = 0;
    chars_drawn = 0;
    rows_checked = 0;
    errors = 0;
  endfunction

  function bit [7:0] symbol(int idx);
    return symbols[idx];
  endfunction

  function int pending();
    return pending_rows.size();
  endfunction

  function void set_reg(logic [1:0] idx, logic [23:0] data);
    case (idx)
      txtr_pkg::REG_ORIGIN_X:   origin_x = data[15:0];
      txtr_pkg::REG_ORIGIN_Y:   origin_y = data[15:0];
      txtr_pkg::REG_SCALE:      scale_reg = data[3:0];
      txtr_pkg::REG_DRAW_COLOR: draw_color = data;
      default: ;
    endcase
  endfunction

  function int glyph_of(bit [7:0] code);
    if (code >= "a" && code <= "z") code = code - ("a" - "A");
    for (int i = 0; i < symbols.len(); i++)
      if (symbols[i] == code) return i;
    return BLANK_GLYPH;
  endfunction

  function bit [39:0] widen(int pattern, int s);
    bit [39:0] acc;
    acc = '0;
    for (int col = GLYPH_W - 1; col >= 0; col--)
      for (int t = 0; t < s; t++)
        acc = {acc[38:0], pattern[col]};
    return acc;
  endfunction

  function void predict_char(bit [7:0] code, bit first);
    int   s;
    int   g;
    int   y;
    row_t r;
    s = scale_reg;
    if (s == 0) s = 1;
    if (s > SCALE_LIMIT) s = SCALE_LIMIT;
    if (first) cursor = int'(origin_x);
    g = glyph_of(code);
    for (int gr = 0; gr < GLYPH_H; gr++) begin
      for (int k = 0; k < s; k++) begin
        y = int'(origin_y) + gr * s + k;
        if (y > COORD_TOP) y = COORD_TOP;
        r.x = cursor[15:0];
        r.y = y[15:0];
        r.bits = widen(glyph_rows[g][gr], s);
        r.color = draw_color;
        r.last = (gr == GLYPH_H - 1) && (k == s - 1);
        pending_rows.push_back(r);
      end
    end
    cursor = cursor + ADVANCE * s;
    if (cursor > COORD_TOP) cursor = COORD_TOP;
    chars_drawn++;
  endfunction

  function void check_row(logic signed [15:0] x, logic signed [15:0] y, logic [39:0] bits,
                          logic [23:0] color, logic last);
    row_t want;
    if (pending_rows.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected row x=%0d y=%0d bits=%h color=%h last=%b",
                 x, y, bits, color, last);
      return;
    end
    want = pending_rows.pop_front();
    if (want.x !== x || want.y !== y || want.bits !== bits || want.color !== color ||
        want.last !== last) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: row %0d expected x=%0d y=%0d bits=%h color=%h last=%b",
                 rows_checked, want.x, want.y, want.bits, want.color, want.last);
        $display("ERROR: row %0d actual   x=%0d y=%0d bits=%h color=%h last=%b",
                 rows_checked, x, y, bits, color, last);
      end
    end
    rows_checked++;
  endfunction

  function void close_out();
    if (pending_rows.size() != 0) begin
      $display("ERROR: %0d predicted rows never appeared", pending_rows.size());
      errors += pending_rows.size();
    end
  endfunction
endclass

module tb_top;
  import txtr_pkg::*;

  localparam int PHASE_ITEMS = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int TIMEOUT = 24_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_char_code;
  logic               in_first;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_pixel_x;
  logic signed [15:0] out_pixel_y;
  logic [ROW_W-1:0]   out_row_bits;
  logic [23:0]        out_row_color;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  glyph_row_checker rows_chk = new();
  int               settings = 0;
  int               rx_hold = 0;
  bit               rx_calm = 1'b0;

  scaled_5x7_text_rasterizer_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_row_bits  (out_row_bits),
    .out_row_color (out_row_color),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      rows_chk.check_row(out_pixel_x, out_pixel_y, out_row_bits, out_row_color, out_last);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin : receiver
    int n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        n = rx_hold;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        rx_hold = 0;
        out_ready <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        n = pick_gap() + 1;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic first, input int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= code;
    in_first <= first;
    do @(posedge clk); while (!in_ready);
    rows_chk.predict_char(code, first);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    rows_chk.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ox, input logic [15:0] oy, input logic [3:0] sc,
                           input logic [23:0] color, input bit calm, input int hold);
    logic [7:0] code;
    logic       first;
    drain();
    write_reg(REG_ORIGIN_X, {8'($urandom), ox});
    write_reg(REG_ORIGIN_Y, {8'($urandom), oy});
    write_reg(REG_SCALE, {20'($urandom), sc});
    write_reg(REG_DRAW_COLOR, color);
    settings++;
    rx_calm = calm;
    rx_hold = hold;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        code = rows_chk.symbol($urandom_range(0, 45));
        if (code >= "A" && code <= "Z" && $urandom_range(0, 1) == 1)
          code = code + ("a" - "A");
      end else begin
        code = 8'($urandom);
      end
      first = (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 9) == 0;
      send_char(code, first, (calm || hold != 0) ? 0 : pick_gap());
    end
  endtask

  initial begin : stimulus
    string      probes;
    logic [7:0] odd_codes [4];
    int         pick;
    logic [3:0] sc;
    in_valid = 1'b0;
    in_char_code = '0;
    in_first = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    rst_n = 1'b0;
    probes = "AzZa09:./-+*=^_, @[`{";
    odd_codes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < probes.len(); i++)
      send_char(probes[i], i == 0 || i == 12, pick_gap());
    foreach (odd_codes[i])
      send_char(odd_codes[i], 1'b0, pick_gap());
    settings++;

    run_phase(16'h8000, 16'h8000, 4'd0, 24'h000000, 1'b1, 0);
    run_phase(16'h7FFF, 16'h7FFF, 4'd8, 24'hFFFFFF, 1'b0, HOLD_CYCLES);
    run_phase(16'd32700, 16'd32740, 4'd15, 24'($urandom), 1'b0, 0);
    run_phase(16'hFFFB, 16'd100, 4'd1, 24'($urandom), 1'b0, 0);
    for (int p = 0; p < 6; p++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        sc = 4'($urandom_range(1, 3));
      end else if (pick < 8) begin
        sc = 4'($urandom_range(4, 8));
      end else begin
        sc = 4'($urandom_range(9, 16));
      end
      run_phase(16'($urandom), 16'($urandom), sc, 24'($urandom), p == 0, 0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    rows_chk.close_out();
    $display("Drew %0d characters and checked %0d rows over %0d register settings.",
             rows_chk.chars_drawn, rows_chk.rows_checked, settings);
    $display("Scales covered zero, one, the maximum and above; coordinates hit both ends.");
    if (rows_chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("ERROR: run did not complete in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
